// File: hw/rtl/mtq_pkg.sv
// Shared constants, types and helpers for the min-tracking queue.
`timescale 1ns / 1ps
package mtq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 2 * DATA_W;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  // Values are stored with the sign bit flipped so unsigned compares order them
  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] EMPTY_MIN = {DATA_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_PUSH = 1'b0;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // latch status of the accepted beat
    logic push;     // write onto the input stack
    logic xfer;     // one step of moving input stack to output stack
    logic pop;      // drop the output stack top, fetch the next minimum
    logic pop_fix;  // take the fetched minimum
    logic emit;     // load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic out_empty;
    logic xfer_done;
  } sts_t;

  function automatic logic [DATA_W-1:0] umin(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// File: hw/rtl/mtq_intf.sv
// Valid/ready channel interfaces for the queue's operation and result beats.
`timescale 1ns / 1ps
interface mtq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [mtq_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface mtq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mtq_pkg::DATA_W-1:0]   min_value;
  logic        [mtq_pkg::COUNT_W-1:0]  entry_count;
  logic        [mtq_pkg::STATUS_W-1:0] status;

  modport source (output valid, output min_value, output entry_count, output status,
                  input ready);
  modport sink (input valid, input min_value, input entry_count, input status,
                output ready);
endinterface

// File: hw/rtl/mtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mtq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/mtq_dp.sv
// Datapath: the two stack RAMs, depth counters, running minima and result register.
`timescale 1ns / 1ps
module mtq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mtq_pkg::cmd_t                       cmd,
  output mtq_pkg::sts_t                       sts,
  input  logic                                in_kind,
  input  logic signed [mtq_pkg::DATA_W-1:0]   in_value,
  output logic signed [mtq_pkg::DATA_W-1:0]   res_min_value,
  output logic        [mtq_pkg::COUNT_W-1:0]  res_entry_count,
  output logic        [mtq_pkg::STATUS_W-1:0] res_status
);

  logic [mtq_pkg::CNT_W-1:0]    in_depth_r, in_depth_nxt;
  logic [mtq_pkg::CNT_W-1:0]    out_depth_r, out_depth_nxt;
  logic [mtq_pkg::DATA_W-1:0]   in_min_r, in_min_nxt;
  logic [mtq_pkg::DATA_W-1:0]   out_min_r, out_min_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic [mtq_pkg::STATUS_W-1:0] status_r;
  logic [mtq_pkg::DATA_W-1:0]   res_min_r;
  logic [mtq_pkg::COUNT_W-1:0]  res_cnt_r;
  logic [mtq_pkg::STATUS_W-1:0] res_status_r;

  logic [mtq_pkg::CNT_W:0]      total;
  logic [mtq_pkg::DATA_W-1:0]   v_flip;
  logic [mtq_pkg::DATA_W-1:0]   push_min;
  logic [mtq_pkg::DATA_W-1:0]   xfer_val;
  logic [mtq_pkg::DATA_W-1:0]   xfer_min;
  logic [mtq_pkg::CNT_W-1:0]    in_dec;
  logic [mtq_pkg::CNT_W-1:0]    out_dec;
  logic [mtq_pkg::CNT_W-1:0]    out_dec2;
  logic [mtq_pkg::STATUS_W-1:0] status_new;

  logic                         in_we, in_re, out_we, out_re;
  logic [mtq_pkg::ADDR_W-1:0]   in_waddr, in_raddr, out_waddr, out_raddr;
  logic [mtq_pkg::ENTRY_W-1:0]  in_wdata, in_rdata, out_wdata, out_rdata;

  // Occupancy and flags
  assign total  = {1'b0, in_depth_r} + {1'b0, out_depth_r};
  assign v_flip = in_value ^ mtq_pkg::SIGN_FLIP;
  assign push_min = mtq_pkg::umin(v_flip, in_min_r);
  assign xfer_val = in_rdata[mtq_pkg::ENTRY_W-1:mtq_pkg::DATA_W];
  assign xfer_min = mtq_pkg::umin(xfer_val, out_min_r);
  assign in_dec   = in_depth_r - 1'b1;
  assign out_dec  = out_depth_r - 1'b1;
  assign out_dec2 = out_depth_r - 2'd2;

  assign sts.is_push   = (in_kind == mtq_pkg::KIND_PUSH);
  assign sts.full      = (total >= (mtq_pkg::CNT_W + 1)'(mtq_pkg::CAPACITY));
  assign sts.empty     = (total == '0);
  assign sts.out_empty = (out_depth_r == '0);
  assign sts.xfer_done = (in_depth_r == '0) && !rd_pend_r;

  always_comb begin
    if (sts.is_push && sts.full) begin
      status_new = mtq_pkg::ST_FULL;
    end else if (!sts.is_push && sts.empty) begin
      status_new = mtq_pkg::ST_EMPTY;
    end else begin
      status_new = mtq_pkg::ST_OK;
    end
  end

  // RAM ports: input stack is written on push, read during a transfer;
  // output stack is written during a transfer, read on pop
  assign in_we     = cmd.push;
  assign in_waddr  = in_depth_r[mtq_pkg::ADDR_W-1:0];
  assign in_wdata  = {v_flip, push_min};
  assign in_re     = cmd.xfer && (in_depth_r != '0);
  assign in_raddr  = in_dec[mtq_pkg::ADDR_W-1:0];
  assign out_we    = cmd.xfer && rd_pend_r;
  assign out_waddr = out_depth_r[mtq_pkg::ADDR_W-1:0];
  assign out_wdata = {xfer_val, xfer_min};
  assign out_re    = cmd.pop;
  assign out_raddr = out_dec2[mtq_pkg::ADDR_W-1:0];

  // Next-state for depths and minima
  always_comb begin
    in_depth_nxt  = in_depth_r;
    out_depth_nxt = out_depth_r;
    in_min_nxt    = in_min_r;
    out_min_nxt   = out_min_r;
    rd_pend_nxt   = rd_pend_r;
    if (cmd.push) begin
      in_depth_nxt = in_depth_r + 1'b1;
      in_min_nxt   = push_min;
    end
    if (cmd.xfer) begin
      // the input stack drains completely, so its minimum ends empty
      in_min_nxt  = mtq_pkg::EMPTY_MIN;
      rd_pend_nxt = in_re;
      if (in_re) begin
        in_depth_nxt = in_dec;
      end
      if (out_we) begin
        out_depth_nxt = out_depth_r + 1'b1;
        out_min_nxt   = xfer_min;
      end
    end
    if (cmd.pop) begin
      out_depth_nxt = out_dec;
    end
    if (cmd.pop_fix) begin
      out_min_nxt = (out_depth_r == '0) ? mtq_pkg::EMPTY_MIN
                                        : out_rdata[mtq_pkg::DATA_W-1:0];
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_depth_r  <= '0;
      out_depth_r <= '0;
      in_min_r    <= mtq_pkg::EMPTY_MIN;
      out_min_r   <= mtq_pkg::EMPTY_MIN;
      rd_pend_r   <= 1'b0;
    end else begin
      in_depth_r  <= in_depth_nxt;
      out_depth_r <= out_depth_nxt;
      in_min_r    <= in_min_nxt;
      out_min_r   <= out_min_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  // Capture status of the beat and load the result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= status_new;
    end
    if (cmd.emit) begin
      res_min_r    <= mtq_pkg::umin(in_min_r, out_min_r) ^ mtq_pkg::SIGN_FLIP;
      res_cnt_r    <= mtq_pkg::COUNT_W'(total);
      res_status_r <= status_r;
    end
  end

  assign res_min_value   = res_min_r;
  assign res_entry_count = res_cnt_r;
  assign res_status      = res_status_r;

  mtq_ram #(
    .WIDTH (mtq_pkg::ENTRY_W),
    .DEPTH (mtq_pkg::CAPACITY)
  ) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  mtq_ram #(
    .WIDTH (mtq_pkg::ENTRY_W),
    .DEPTH (mtq_pkg::CAPACITY)
  ) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .re    (out_re),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

endmodule

// File: hw/rtl/mtq_ctrl.sv
// Controller: sequences push, transfer and pop steps and the result handshake.
`timescale 1ns / 1ps
module mtq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mtq_pkg::sts_t sts,
  output mtq_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_XFER    = 3'd1;
  localparam logic [2:0] S_POP     = 3'd2;
  localparam logic [2:0] S_POP_FIX = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.push = sts.is_push && !sts.full;
          if (sts.is_push || sts.empty) begin
            state_nxt = S_EMIT;
          end else if (sts.out_empty) begin
            state_nxt = S_XFER;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_XFER: begin
        if (sts.xfer_done) begin
          state_nxt = S_POP;
        end else begin
          cmd.xfer = 1'b1;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_POP_FIX;
      end
      S_POP_FIX: begin
        cmd.pop_fix = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beat valid: set on emit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/min_tracking_queue_unit.sv
// Min-tracking FIFO of signed 32-bit values built from two RAM-backed stacks.
//
// Usage:
//   in_chan carries one operation per beat: kind 0 pushes value, kind 1 pops
//   the oldest entry. out_chan returns one result beat per operation: the
//   minimum of the contents afterwards (2147483647 when empty), the entry
//   count and a status (ok, push refused when full, pop refused when empty).
//   Refused operations leave the queue unchanged.
// Sequence: a push or refused operation goes from the accept straight to the
//   emit state, which loads the result register; a pop with entries on the
//   output stack passes the pop and pop-fix states first. A pop with an empty
//   output stack first moves the input stack over, one entry per cycle, set by
//   the single read port of the input stack RAM, then drains the read pipeline
//   and sees the stack empty. One operation is in work at a time and the next
//   is accepted once the previous result sits in the output register.
//   Each entry moves once between the stacks.
// Reset: depths clear, minima read as empty; RAM contents are not cleared and
//   no clearing pass runs. The block is ready the cycle after reset.
// Stall: a held result blocks the next result; the finished operation waits
//   and no further operation is accepted until the result register frees.
`timescale 1ns / 1ps
module min_tracking_queue_unit (
  input  logic              clk,
  input  logic              rst_n,
  mtq_in_if.sink            in_chan,
  mtq_out_if.source         out_chan
);

  mtq_pkg::cmd_t cmd;
  mtq_pkg::sts_t sts;

  mtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_chan.kind),
    .in_value        (in_chan.value),
    .res_min_value   (out_chan.min_value),
    .res_entry_count (out_chan.entry_count),
    .res_status      (out_chan.status)
  );

endmodule
